@@ hw/rtl/bca_pkg.sv @@
// shared types, codes and widths for the bounded compacting word list
`timescale 1ns / 1ps
package bca_pkg;

  localparam int WORD_W          = 32;
  localparam int POS_W           = 6;
  localparam int CAP_W           = 7;
  localparam int COUNT_W         = 7;
  localparam int REQ_W           = 3;
  localparam int STATUS_W        = 2;
  localparam int DEF_MAX_ENTRIES = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } req_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   word_out;
    logic [COUNT_W-1:0]  count_now;
  } rsp_beat_t;

  // broadcast to every cell, already qualified by range and fullness checks
  typedef struct packed {
    logic             app_en;
    logic             wr_en;
    logic             rd_en;
    logic             rm_en;
    logic [POS_W-1:0] pos;
  } cell_cmd_t;

endpackage

@@ hw/rtl/bounded_compacting_array.sv @@
// top level: ordered list of 32-bit words held in a row of shifting cells
//
// Requests arrive on the req channel (req_valid / req_stall / req) and each one
// gives exactly one beat on the rsp channel (rsp_valid / rsp_stall / rsp).
// Request types: append, read, write, remove (later entries move down one
// place) and erase all. Every response carries a status and the entry count
// after the request; a read returns the entry, other requests return zero.
// The response is registered: a beat accepted at one edge is offered on rsp
// from the next edge on. One request is taken per cycle while rsp is drained,
// since every entry has its own cell and a remove shifts all higher cells at
// once. The single response register sets the rate: when it holds a beat and
// rsp_stall is high, req_stall goes high and the held beat stays unchanged.
// The capacity register is written through cfg_wr_en / cfg_wr_data; appends
// beyond min(capacity, MAX_ENTRIES) answer list full.
// Reset (rst, synchronous) empties the list, drops any pending response and
// sets the capacity to 64. Entry contents are not cleared and are only ever
// read after being written.
`timescale 1ns / 1ps
module bounded_compacting_array #(
  parameter int MAX_ENTRIES = bca_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  bca_pkg::req_beat_t        req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output bca_pkg::rsp_beat_t        rsp,
  input  logic                      cfg_wr_en,
  input  logic [bca_pkg::CAP_W-1:0] cfg_wr_data
);
  import bca_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic [CAP_W-1:0]    cap_limit;
  logic                accept;
  logic                full;
  logic                in_range;
  logic [STATUS_W-1:0] status_next;
  cell_cmd_t           cmd;
  logic [WORD_W-1:0]   rd_word;

  logic [WORD_W-1:0] cell_data [MAX_ENTRIES];
  logic [WORD_W-1:0] cell_rd   [MAX_ENTRIES];

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  assign full     = (32'(count) >= 32'(cap_limit)) || (32'(count) >= 32'(MAX_ENTRIES));
  assign in_range = (32'(req.position) < 32'(count));

  always_comb begin
    cmd         = '0;
    cmd.pos     = req.position;
    count_next  = count;
    status_next = ST_OK;
    case (req.req_type)
      REQ_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          cmd.app_en = accept;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_READ: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.wr_en = accept;
        end
      end
      REQ_REMOVE: begin
        if (!in_range) begin
          status_next = ST_RANGE;
        end else begin
          cmd.rm_en  = accept;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_ERASE: begin
        count_next = '0;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [WORD_W-1:0] upper;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end

    bca_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .tail    (count),
      .word_in (req.word_in),
      .upper   (upper),
      .data    (cell_data[i]),
      .rd_word (cell_rd[i])
    );
  end

  // at most one cell drives a non-zero read word
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cap_limit <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_limit <= cfg_wr_data;
      end
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status    <= status_next;
      rsp.word_out  <= rd_word;
      rsp.count_now <= COUNT_W'(count_next);
    end
  end

  // count never passes the built depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(MAX_ENTRIES))
    else $error("entry count beyond built depth");

  // a good append grows the list by exactly one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.req_type == REQ_APPEND && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("append did not grow the count");

  // every accepted beat leaves a response behind
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted beat without response");

  // a stalled response is not overwritten
  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response lost");

  // the reported count tracks the register
  a_count_report: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.count_now == COUNT_W'(count)))
    else $error("reported count differs from stored count");

endmodule

@@ hw/rtl/bca_cell.sv @@
// one storage cell of the list: holds one entry and shifts from its upper neighbour
`timescale 1ns / 1ps
module bca_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                       clk,
  input  bca_pkg::cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]           tail,
  input  logic [bca_pkg::WORD_W-1:0] word_in,
  input  logic [bca_pkg::WORD_W-1:0] upper,
  output logic [bca_pkg::WORD_W-1:0] data,
  output logic [bca_pkg::WORD_W-1:0] rd_word
);
  import bca_pkg::*;

  logic              hit_pos;
  logic              hit_tail;
  logic              at_or_above;
  logic [WORD_W-1:0] data_next;

  assign hit_pos     = (32'(cmd.pos) == 32'(IDX));
  assign hit_tail    = (32'(tail) == 32'(IDX));
  assign at_or_above = (32'(IDX) >= 32'(cmd.pos));

  always_comb begin
    data_next = data;
    if (cmd.app_en && hit_tail) begin
      data_next = word_in;
    end else if (cmd.wr_en && hit_pos) begin
      data_next = word_in;
    end else if (cmd.rm_en && at_or_above) begin
      data_next = upper;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  assign rd_word = (cmd.rd_en && hit_pos) ? data : '0;

endmodule

@@ dv/bounded_compacting_array_checker.sv @@
// checker for the compacting word list: shadow list, predicted responses and compare
`timescale 1ns / 1ps
module bounded_compacting_array_checker #(
  parameter int DEPTH = bca_pkg::DEF_MAX_ENTRIES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  logic                      req_stall,
  input  bca_pkg::req_beat_t        req,
  input  logic                      rsp_valid,
  input  logic                      rsp_stall,
  input  bca_pkg::rsp_beat_t        rsp,
  input  logic                      cfg_wr_en,
  input  logic [bca_pkg::CAP_W-1:0] cfg_wr_data,
  output int                        errors,
  output int                        pending
);
  import bca_pkg::*;

  logic [WORD_W-1:0]  shadow_words [DEPTH];
  logic [COUNT_W-1:0] shadow_count;
  logic [CAP_W-1:0]   shadow_cap;
  rsp_beat_t          rsp_due_q [$];
  rsp_beat_t          want;

  // applies one request to the shadow list and returns the response it should give
  function automatic rsp_beat_t list_apply(input req_beat_t r);
    rsp_beat_t          o;
    logic [COUNT_W-1:0] lim;
    logic               hit;
    int                 i;
    o   = '0;
    lim = (shadow_cap > DEPTH) ? COUNT_W'(DEPTH) : shadow_cap;
    hit = (COUNT_W'(r.position) < shadow_count);
    case (r.req_type)
      REQ_APPEND: begin
        if (shadow_count >= lim) begin
          o.status = ST_FULL;
        end else begin
          shadow_words[shadow_count[POS_W-1:0]] = r.word_in;
          shadow_count = shadow_count + COUNT_W'(1);
        end
      end
      REQ_READ: begin
        if (!hit) o.status = ST_RANGE;
        else o.word_out = shadow_words[r.position];
      end
      REQ_WRITE: begin
        if (!hit) o.status = ST_RANGE;
        else shadow_words[r.position] = r.word_in;
      end
      REQ_REMOVE: begin
        if (!hit) begin
          o.status = ST_RANGE;
        end else begin
          // close the gap, later entries move down one place
          for (i = int'(r.position); i + 1 < int'(shadow_count); i++) begin
            shadow_words[i] = shadow_words[i + 1];
          end
          shadow_count = shadow_count - COUNT_W'(1);
        end
      end
      REQ_ERASE: begin
        shadow_count = '0;
      end
      default: begin
      end
    endcase
    o.count_now = shadow_count;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = '0;
      shadow_cap   = CAP_RESET;
      rsp_due_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (cfg_wr_en) shadow_cap = cfg_wr_data;
      if (req_valid && !req_stall) rsp_due_q.push_back(list_apply(req));
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due_q.size() == 0) begin
          $error("rsp beat with nothing outstanding: status %0d word_out %h count_now %0d",
                 rsp.status, rsp.word_out, rsp.count_now);
          errors++;
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.word_out !== want.word_out) begin
            $error("word_out: expected %h, got %h", want.word_out, rsp.word_out);
            errors++;
          end
          if (rsp.count_now !== want.count_now) begin
            $error("count_now: expected %0d, got %0d", want.count_now, rsp.count_now);
            errors++;
          end
        end
      end
      pending <= rsp_due_q.size();
    end
  end

endmodule

@@ dv/bounded_compacting_array_test.sv @@
// testbench top for the compacting word list: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module bounded_compacting_array_test;
  import bca_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNUSED_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_beat_t        req = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_beat_t        rsp;
  logic             cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  int               errors;
  int               pending;
  int               idle_run = 0;
  int               stall_left = 0;
  logic             calm = 1'b1;
  int               fill = 0;
  logic [CAP_W-1:0] cap_now = CAP_RESET;

  bounded_compacting_array dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  bounded_compacting_array_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left <= gap_len() - 1;
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("bounded_compacting_array regression: fail");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // offers one beat and holds it until taken; valid stays high afterwards
  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                          input logic [WORD_W-1:0] word);
    int lim;
    req.req_type <= kind;
    req.position <= pos;
    req.word_in  <= word;
    req_valid    <= 1'b1;
    do @(posedge clk); while (req_stall);
    // rough count, only used to aim positions
    lim = (cap_now > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(cap_now);
    case (kind)
      REQ_APPEND: if (fill < lim) fill++;
      REQ_REMOVE: if (int'(pos) < fill) fill--;
      REQ_ERASE:  fill = 0;
      default: begin
      end
    endcase
  endtask

  task automatic pause_req(input int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_rsp();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_cap(input logic [CAP_W-1:0] v);
    drain_rsp();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_now = v;
  endtask

  task automatic random_req(input int append_pct);
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    int               roll;
    roll = $urandom_range(0, 99);
    if (roll < append_pct) begin
      kind = REQ_APPEND;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 36) kind = REQ_READ;
      else if (roll < 64) kind = REQ_WRITE;
      else if (roll < 96) kind = REQ_REMOVE;
      else if (roll < 98) kind = REQ_ERASE;
      else kind = REQ_UNUSED_LO + REQ_W'($urandom_range(0, 2));
    end
    if (fill > 0 && $urandom_range(0, 9) < 8) pos = POS_W'($urandom_range(0, fill - 1));
    else if (fill < DEF_MAX_ENTRIES && $urandom_range(0, 1) == 1) pos = POS_W'(fill);
    else pos = POS_W'($urandom);
    push_req(kind, pos, $urandom);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int n, input int append_pct);
    int k;
    set_cap(cap);
    for (k = 0; k < n; k++) begin
      if (k % 40 == 0) calm = ($urandom_range(0, 9) < 3);
      if (!calm && $urandom_range(0, 99) < 30) pause_req(gap_len());
      else if ($urandom_range(0, 199) == 0) drain_rsp();
      random_req(append_pct);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every indexed request is out of range
    push_req(REQ_READ, 6'd0, 32'h0);
    push_req(REQ_WRITE, 6'd0, 32'hDEAD_BEEF);
    push_req(REQ_REMOVE, 6'd0, 32'h0);
    push_req(REQ_APPEND, 6'd0, 32'h0000_0000);
    push_req(REQ_APPEND, 6'd63, 32'hFFFF_FFFF);
    push_req(REQ_APPEND, 6'd0, 32'hA5A5_5A5A);
    push_req(REQ_READ, 6'd0, 32'hFFFF_FFFF);
    push_req(REQ_READ, 6'd1, 32'h0);
    push_req(REQ_READ, 6'd3, 32'h0);
    push_req(REQ_READ, 6'd63, 32'h0);
    push_req(REQ_WRITE, 6'd1, 32'h1234_5678);
    push_req(REQ_READ, 6'd1, 32'h0);
    // remove from the front, the rest must move down
    push_req(REQ_REMOVE, 6'd0, 32'h0);
    push_req(REQ_READ, 6'd0, 32'h0);
    push_req(REQ_READ, 6'd1, 32'h0);
    push_req(REQ_UNUSED_LO, 6'd0, 32'h0);
    push_req(REQ_UNUSED_MID, 6'd63, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED_HI, 6'd1, 32'h0);
    push_req(REQ_ERASE, 6'd0, 32'h0);
    push_req(REQ_READ, 6'd0, 32'h0);

    // one-entry limit, then a limit of zero
    set_cap(7'd1);
    push_req(REQ_APPEND, 6'd0, 32'h0BAD_F00D);
    push_req(REQ_APPEND, 6'd0, 32'h1111_1111);
    push_req(REQ_REMOVE, 6'd0, 32'h0);
    push_req(REQ_APPEND, 6'd0, 32'h8000_0001);
    set_cap(7'd0);
    push_req(REQ_APPEND, 6'd0, 32'h7FFF_FFFF);
    push_req(REQ_READ, 6'd0, 32'h0);
    push_req(REQ_ERASE, 6'd0, 32'h0);

    // limit above the built depth saturates; then lowered below the count
    run_phase(7'd127, 250, 60);
    run_phase(7'd40, 200, 20);
    run_phase(7'd64, 150, 45);
    run_phase(7'd1, 80, 50);
    run_phase(7'd0, 60, 40);
    run_phase(7'd2, 80, 50);
    run_phase(CAP_W'($urandom_range(3, 63)), 200, 55);
    run_phase(7'd64, 180, 50);

    drain_rsp();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("bounded_compacting_array regression: pass");
    end else begin
      $display("bounded_compacting_array regression: fail");
    end
    $finish;
  end

endmodule
